// ===== rtl/smmc_pkg.sv =====
// Package for the swarm membership message coalescer.
// Holds command, status, kind and state codes; no dependencies.
package smmc_pkg;

    typedef enum logic [2:0] {
        CMD_JOIN       = 3'd0,
        CMD_LEAVE      = 3'd1,
        CMD_LIST_START = 3'd2,
        CMD_LIST_ADD   = 3'd3,
        CMD_PEEK       = 3'd4,
        CMD_DROP       = 3'd5
    } t_cmd;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_LIST  = 2'd1;
    localparam logic [1:0] K_JOIN  = 2'd2;
    localparam logic [1:0] K_LEAVE = 2'd3;

    // Selects which store the sequencer works on.
    typedef enum logic [1:0] {
        SEL_LIST  = 2'd0,
        SEL_JOIN  = 2'd1,
        SEL_LEAVE = 2'd2
    } t_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,      // walk store looking for id
        S_FIND_WAIT, // last read lands
        S_SHIFT,     // ordered removal: read i+1
        S_SHIFT_WR,  // write it to i
        S_APPEND,
        S_NEXT,      // after search/removal: other fifo, append or finish
        S_PEEK_HDR,
        S_PEEK_CNT,
        S_PEEK_RD,
        S_PEEK_OUT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/smmc_store.sv =====
// One synchronous store with a registered read port.
// Depends on nothing; used by the coalescer top level.
module smmc_store #(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [15:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [15:0]              o_rdata
);
    logic [15:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/swarm_membership_msg_coalescer_unit.sv =====
// Top level of the swarm membership message coalescer.
// Depends on smmc_pkg and smmc_store (three instances: list, join, leave).
//
// channel | ports                                   | transfer
// --------+-----------------------------------------+-----------------------------
// item in | i_start, i_command, i_member_id, o_busy | i_start && !o_busy
// result  | o_strobe, o_status, o_kind, o_word,      | every cycle o_strobe is high
//         | o_last                                  |
// config  | i_cfg_we, i_cfg_wdata                   | every cycle i_cfg_we is high
//
// One item at a time. A join or leave searches a store entry by entry (read,
// then compare), and with no list pending a second store after the first; an
// ordered removal moves each later entry down (read, then write). A peek sends
// its header words on consecutive cycles, then each list id in turn (read, send).
// Reset clears counts, the pending flag and robot id; stores are not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
module swarm_membership_msg_coalescer_unit #(
    parameter int LIST_DEPTH  = 32,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_member_id,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [1:0]  o_kind,
    output logic [15:0] o_word,
    output logic        o_last
);
    localparam int LA = $clog2(LIST_DEPTH);
    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int AW = (LA > QA) ? LA : QA;
    localparam int CW = AW + 1;

    smmc_pkg::t_state r_state, n_state;
    smmc_pkg::t_sel   r_sel, n_sel;
    logic [2:0]  r_cmd, n_cmd;
    logic [15:0] r_id, n_id;
    logic [15:0] r_robot;
    logic        r_pend, n_pend;
    logic [CW-1:0] r_lcnt, n_lcnt, r_jcnt, n_jcnt, r_vcnt, n_vcnt;
    logic [CW-1:0] r_idx, n_idx;   // walk pointer
    logic [1:0]  r_st, n_st;
    // result register
    logic        r_stb, n_stb, r_last, n_last;
    logic [1:0]  r_ost, n_ost, r_kind, n_kind;
    logic [15:0] r_word, n_word;

    // store ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rd_l, rd_j, rd_v, rd;

    smmc_store #(.DEPTH(LIST_DEPTH)) u_list (
        .i_clk(i_clk), .i_we(we && r_sel == smmc_pkg::SEL_LIST),
        .i_waddr(waddr[LA-1:0]), .i_wdata(wdata),
        .i_raddr(raddr[LA-1:0]), .o_rdata(rd_l));
    smmc_store #(.DEPTH(QUEUE_DEPTH)) u_join (
        .i_clk(i_clk), .i_we(we && r_sel == smmc_pkg::SEL_JOIN),
        .i_waddr(waddr[QA-1:0]), .i_wdata(wdata),
        .i_raddr(raddr[QA-1:0]), .o_rdata(rd_j));
    smmc_store #(.DEPTH(QUEUE_DEPTH)) u_leave (
        .i_clk(i_clk), .i_we(we && r_sel == smmc_pkg::SEL_LEAVE),
        .i_waddr(waddr[QA-1:0]), .i_wdata(wdata),
        .i_raddr(raddr[QA-1:0]), .o_rdata(rd_v));

    // read data of the store selected in the previous cycle
    smmc_pkg::t_sel r_rsel;
    always_ff @(posedge i_clk) r_rsel <= r_sel;
    always_comb begin
        case (r_rsel)
            smmc_pkg::SEL_LIST: rd = rd_l;
            smmc_pkg::SEL_JOIN: rd = rd_j;
            default:            rd = rd_v;
        endcase
    end

    logic [CW-1:0] cur_cnt, cur_cap;
    always_comb begin
        case (r_sel)
            smmc_pkg::SEL_LIST: begin
                cur_cnt = r_lcnt; cur_cap = CW'(LIST_DEPTH);
            end
            smmc_pkg::SEL_JOIN: begin
                cur_cnt = r_jcnt; cur_cap = CW'(QUEUE_DEPTH);
            end
            default: begin
                cur_cnt = r_vcnt; cur_cap = CW'(QUEUE_DEPTH);
            end
        endcase
    end

    assign o_busy = (r_state != smmc_pkg::S_IDLE);

    // r_idx is the walk pointer: a search reads entry r_idx, then checks it;
    // a removal reads entry r_idx+1, then writes it to r_idx.
    // With no list pending, a join or leave first works on the join fifo and
    // then on the leave fifo.
    always_comb begin
        n_state = r_state; n_sel = r_sel; n_cmd = r_cmd; n_id = r_id;
        n_pend = r_pend; n_lcnt = r_lcnt; n_jcnt = r_jcnt; n_vcnt = r_vcnt;
        n_idx = r_idx; n_st = r_st;
        n_stb = 1'b0; n_last = 1'b0; n_ost = smmc_pkg::ST_OK;
        n_kind = smmc_pkg::K_NONE; n_word = 16'd0;
        we = 1'b0; waddr = r_idx[AW-1:0]; wdata = r_id;
        raddr = r_idx[AW-1:0];
        case (r_state)
            smmc_pkg::S_IDLE: begin
                raddr = '0;
                if (i_start) begin
                    n_cmd = i_command; n_id = i_member_id; n_idx = '0;
                    n_st = smmc_pkg::ST_OK;
                    case (i_command)
                        smmc_pkg::CMD_JOIN, smmc_pkg::CMD_LEAVE: begin
                            if (r_pend) n_sel = smmc_pkg::SEL_LIST;
                            else n_sel = smmc_pkg::SEL_JOIN;
                            n_state = smmc_pkg::S_FIND;
                        end
                        smmc_pkg::CMD_LIST_START: begin
                            n_pend = 1'b1; n_lcnt = '0; n_jcnt = '0; n_vcnt = '0;
                            n_state = smmc_pkg::S_DONE;
                        end
                        smmc_pkg::CMD_LIST_ADD: begin
                            n_sel = smmc_pkg::SEL_LIST;
                            if (r_pend) n_state = smmc_pkg::S_APPEND;
                            else begin
                                n_st = smmc_pkg::ST_NONE; n_state = smmc_pkg::S_DONE;
                            end
                        end
                        smmc_pkg::CMD_PEEK: begin
                            if (r_pend) n_sel = smmc_pkg::SEL_LIST;
                            else if (r_jcnt != '0) n_sel = smmc_pkg::SEL_JOIN;
                            else n_sel = smmc_pkg::SEL_LEAVE;
                            if (r_pend || r_jcnt != '0 || r_vcnt != '0)
                                n_state = smmc_pkg::S_PEEK_HDR;
                            else begin
                                n_st = smmc_pkg::ST_NONE; n_state = smmc_pkg::S_DONE;
                            end
                        end
                        smmc_pkg::CMD_DROP: begin
                            if (r_pend) begin
                                n_pend = 1'b0; n_lcnt = '0;
                                n_stb = 1'b1; n_last = 1'b1;
                                n_kind = smmc_pkg::K_LIST; n_state = smmc_pkg::S_IDLE;
                            end else if (r_jcnt != '0) begin
                                n_sel = smmc_pkg::SEL_JOIN; n_idx = '0;
                                n_state = smmc_pkg::S_SHIFT;
                            end else if (r_vcnt != '0) begin
                                n_sel = smmc_pkg::SEL_LEAVE; n_idx = '0;
                                n_state = smmc_pkg::S_SHIFT;
                            end else begin
                                n_stb = 1'b1; n_last = 1'b1;
                                n_ost = smmc_pkg::ST_NONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            smmc_pkg::S_FIND: begin
                // issue read at r_idx; data checked in S_FIND_WAIT
                if (r_idx >= cur_cnt) begin
                    n_state = smmc_pkg::S_NEXT; // not found
                end else begin
                    n_state = smmc_pkg::S_FIND_WAIT;
                end
            end
            smmc_pkg::S_FIND_WAIT: begin
                if (rd == r_id) begin
                    // found: a leave removes it from the list or join fifo,
                    // a join cancels it from the leave fifo
                    if ((r_cmd == smmc_pkg::CMD_LEAVE && r_sel != smmc_pkg::SEL_LEAVE)
                        || (r_cmd == smmc_pkg::CMD_JOIN
                            && r_sel == smmc_pkg::SEL_LEAVE)) begin
                        n_state = smmc_pkg::S_SHIFT;
                    end else if (r_cmd == smmc_pkg::CMD_JOIN
                                 && r_sel == smmc_pkg::SEL_JOIN) begin
                        // already queued: skip the append, cancel a leave
                        n_sel = smmc_pkg::SEL_LEAVE; n_idx = '0;
                        n_state = smmc_pkg::S_FIND;
                    end else begin
                        n_state = smmc_pkg::S_DONE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = smmc_pkg::S_FIND;
                end
            end
            smmc_pkg::S_SHIFT: begin
                // move entry idx+1 down to idx
                if (r_idx + 1'b1 >= cur_cnt) begin
                    case (r_sel)
                        smmc_pkg::SEL_LIST: n_lcnt = r_lcnt - 1'b1;
                        smmc_pkg::SEL_JOIN: n_jcnt = r_jcnt - 1'b1;
                        default:            n_vcnt = r_vcnt - 1'b1;
                    endcase
                    n_state = smmc_pkg::S_NEXT;
                end else begin
                    raddr = AW'(r_idx + 1'b1);
                    n_state = smmc_pkg::S_SHIFT_WR;
                end
            end
            smmc_pkg::S_SHIFT_WR: begin
                we = 1'b1; wdata = rd;
                n_idx = r_idx + 1'b1;
                n_state = smmc_pkg::S_SHIFT;
            end
            smmc_pkg::S_NEXT: begin
                // sequencing after a search or removal in r_sel
                n_idx = '0;
                if (r_cmd == smmc_pkg::CMD_DROP) begin
                    n_stb = 1'b1; n_last = 1'b1;
                    n_kind = (r_sel == smmc_pkg::SEL_JOIN)
                             ? smmc_pkg::K_JOIN : smmc_pkg::K_LEAVE;
                    n_state = smmc_pkg::S_IDLE;
                end else if (r_sel == smmc_pkg::SEL_LIST) begin
                    n_state = (r_cmd == smmc_pkg::CMD_JOIN)
                              ? smmc_pkg::S_APPEND : smmc_pkg::S_DONE;
                end else if (r_cmd == smmc_pkg::CMD_JOIN
                             && r_sel == smmc_pkg::SEL_JOIN) begin
                    n_state = smmc_pkg::S_APPEND; // absent from join fifo
                end else if (r_cmd == smmc_pkg::CMD_LEAVE
                             && r_sel == smmc_pkg::SEL_LEAVE) begin
                    n_state = smmc_pkg::S_APPEND;
                end else if (r_cmd == smmc_pkg::CMD_LEAVE) begin
                    // leave: join fifo cleaned, now search leave fifo
                    n_sel = smmc_pkg::SEL_LEAVE; n_state = smmc_pkg::S_FIND;
                end else begin
                    n_state = smmc_pkg::S_DONE; // join: leave fifo cleaned
                end
            end
            smmc_pkg::S_APPEND: begin
                if (cur_cnt >= cur_cap) begin
                    n_st = smmc_pkg::ST_FULL;
                end else begin
                    we = 1'b1; waddr = cur_cnt[AW-1:0]; wdata = r_id;
                    case (r_sel)
                        smmc_pkg::SEL_LIST: n_lcnt = r_lcnt + 1'b1;
                        smmc_pkg::SEL_JOIN: n_jcnt = r_jcnt + 1'b1;
                        default:            n_vcnt = r_vcnt + 1'b1;
                    endcase
                end
                n_idx = '0;
                if (r_cmd == smmc_pkg::CMD_JOIN && r_sel == smmc_pkg::SEL_JOIN) begin
                    // cancel a matching leave even when the join fifo is full
                    n_sel = smmc_pkg::SEL_LEAVE;
                    n_state = smmc_pkg::S_FIND;
                end else begin
                    n_state = smmc_pkg::S_DONE;
                end
            end
            smmc_pkg::S_PEEK_HDR: begin
                n_stb = 1'b1; n_word = r_robot;
                n_kind = (r_sel == smmc_pkg::SEL_LIST) ? smmc_pkg::K_LIST :
                         (r_sel == smmc_pkg::SEL_JOIN) ? smmc_pkg::K_JOIN
                                                       : smmc_pkg::K_LEAVE;
                raddr = '0;
                n_state = (r_sel == smmc_pkg::SEL_LIST)
                          ? smmc_pkg::S_PEEK_CNT : smmc_pkg::S_PEEK_OUT;
                n_idx = (r_sel == smmc_pkg::SEL_LIST) ? '0 : CW'(1);
            end
            smmc_pkg::S_PEEK_CNT: begin
                n_stb = 1'b1; n_kind = smmc_pkg::K_LIST;
                n_word = 16'(r_lcnt); n_last = (r_lcnt == '0);
                n_state = (r_lcnt == '0) ? smmc_pkg::S_IDLE : smmc_pkg::S_PEEK_RD;
            end
            smmc_pkg::S_PEEK_RD: begin
                n_state = smmc_pkg::S_PEEK_OUT;
                n_idx = r_idx + 1'b1;
            end
            smmc_pkg::S_PEEK_OUT: begin
                n_stb = 1'b1; n_word = rd;
                n_kind = (r_sel == smmc_pkg::SEL_LIST) ? smmc_pkg::K_LIST :
                         (r_sel == smmc_pkg::SEL_JOIN) ? smmc_pkg::K_JOIN
                                                       : smmc_pkg::K_LEAVE;
                n_last = (r_sel != smmc_pkg::SEL_LIST) || (r_idx == r_lcnt);
                n_state = n_last ? smmc_pkg::S_IDLE : smmc_pkg::S_PEEK_RD;
            end
            smmc_pkg::S_DONE: begin
                n_stb = 1'b1; n_last = 1'b1; n_ost = r_st;
                n_state = smmc_pkg::S_IDLE;
            end
            default: n_state = smmc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smmc_pkg::S_IDLE;
            r_pend  <= 1'b0;
            r_lcnt  <= '0; r_jcnt <= '0; r_vcnt <= '0;
            r_robot <= 16'd0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_lcnt  <= n_lcnt; r_jcnt <= n_jcnt; r_vcnt <= n_vcnt;
            if (i_cfg_we) r_robot <= i_cfg_wdata;
            r_stb   <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel; r_cmd <= n_cmd; r_id <= n_id; r_idx <= n_idx;
        r_st <= n_st; r_last <= n_last; r_ost <= n_ost;
        r_kind <= n_kind; r_word <= n_word;
    end

    assign o_strobe = r_stb;
    assign o_status = r_ost;
    assign o_kind   = r_kind;
    assign o_word   = r_word;
    assign o_last   = r_last;

    a_cnt_l: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcnt <= CW'(LIST_DEPTH)) else $error("list count over depth");
    a_cnt_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jcnt <= CW'(QUEUE_DEPTH) && r_vcnt <= CW'(QUEUE_DEPTH))
        else $error("queue count over depth");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stb && r_last |-> r_state == smmc_pkg::S_IDLE)
        else $error("final result while still working");
    a_pend_lists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && r_state == smmc_pkg::S_IDLE |-> r_jcnt == '0 && r_vcnt == '0)
        else $error("fifo entries while list pending");
endmodule

// ===== test/swarm_membership_msg_coalescer_unit_tb.sv =====
// Self-checking testbench for swarm_membership_msg_coalescer_unit.
// Depends on smmc_pkg and the coalescer RTL; predicts every result word in-line.
module swarm_membership_msg_coalescer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = 32;
    localparam int QUEUE_DEPTH = 32;
    localparam int WATCHDOG    = 5000;
    // Two walks plus an ordered removal on a full store stay under this.
    localparam int SETTLE      = 200;

    // Commands outside the defined set; the block ignores them.
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [2:0]  i_command = '0;
    logic [15:0] i_member_id = '0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [1:0]  o_kind;
    logic [15:0] o_word;
    logic        o_last;

    swarm_membership_msg_coalescer_unit #(
        .LIST_DEPTH (LIST_DEPTH),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_command  (i_command),
        .i_member_id(i_member_id),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_kind     (o_kind),
        .o_word     (o_word),
        .o_last     (o_last)
    );

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [15:0] word;
        logic        last;
    } t_msg_word;

    // Shadow copy of the block's stores, counts and register.
    logic [15:0] own_id;
    logic        list_open;
    logic [15:0] members [LIST_DEPTH];
    int          n_members;
    logic [15:0] joins [QUEUE_DEPTH];
    int          n_joins;
    logic [15:0] leaves [QUEUE_DEPTH];
    int          n_leaves;

    t_msg_word   words_due [$];
    int          n_errors = 0;
    int          idle_pct = 0;
    int          quiet_cycles = 0;

    function automatic t_msg_word mk(logic [1:0] st, logic [1:0] k, logic [15:0] w,
                                     logic l);
        t_msg_word m;
        m.status = st;
        m.kind   = k;
        m.word   = w;
        m.last   = l;
        return m;
    endfunction

    function automatic int find_member(int sel, logic [15:0] id);
        int n;
        n = (sel == 0) ? n_members : (sel == 1) ? n_joins : n_leaves;
        for (int i = 0; i < n; i++) begin
            if (sel == 0 && members[i] == id) return i;
            if (sel == 1 && joins[i] == id) return i;
            if (sel == 2 && leaves[i] == id) return i;
        end
        return n;
    endfunction

    // Ordered removal: close the gap, keep the order of the rest.
    function automatic void remove_entry(int sel, int pos);
        if (sel == 0) begin
            if (pos >= n_members) return;
            for (int i = pos; i + 1 < n_members; i++) members[i] = members[i+1];
            n_members--;
        end else if (sel == 1) begin
            if (pos >= n_joins) return;
            for (int i = pos; i + 1 < n_joins; i++) joins[i] = joins[i+1];
            n_joins--;
        end else begin
            if (pos >= n_leaves) return;
            for (int i = pos; i + 1 < n_leaves; i++) leaves[i] = leaves[i+1];
            n_leaves--;
        end
    endfunction

    function automatic logic [1:0] add_member(logic [15:0] id);
        if (n_members >= LIST_DEPTH) return smmc_pkg::ST_FULL;
        members[n_members++] = id;
        return smmc_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] queue_unique(int sel, logic [15:0] id);
        int n;
        n = (sel == 1) ? n_joins : n_leaves;
        if (find_member(sel, id) < n) return smmc_pkg::ST_OK;
        if (n >= QUEUE_DEPTH) return smmc_pkg::ST_FULL;
        if (sel == 1) joins[n_joins++] = id;
        else leaves[n_leaves++] = id;
        return smmc_pkg::ST_OK;
    endfunction

    // Advance the shadow state by one transfer and queue the words it emits.
    function automatic void coalesce(logic [2:0] cmd, logic [15:0] id);
        logic [1:0] st;
        st = smmc_pkg::ST_OK;
        case (cmd)
            smmc_pkg::CMD_JOIN: begin
                if (list_open) begin
                    if (find_member(0, id) == n_members) st = add_member(id);
                end else begin
                    st = queue_unique(1, id);
                    remove_entry(2, find_member(2, id));
                end
                words_due.push_back(mk(st, smmc_pkg::K_NONE, '0, 1'b1));
            end
            smmc_pkg::CMD_LEAVE: begin
                if (list_open) begin
                    remove_entry(0, find_member(0, id));
                end else begin
                    remove_entry(1, find_member(1, id));
                    st = queue_unique(2, id);
                end
                words_due.push_back(mk(st, smmc_pkg::K_NONE, '0, 1'b1));
            end
            smmc_pkg::CMD_LIST_START: begin
                list_open = 1'b1;
                n_members = 0;
                n_joins   = 0;
                n_leaves  = 0;
                words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_NONE, '0, 1'b1));
            end
            smmc_pkg::CMD_LIST_ADD: begin
                st = list_open ? add_member(id) : smmc_pkg::ST_NONE;
                words_due.push_back(mk(st, smmc_pkg::K_NONE, '0, 1'b1));
            end
            smmc_pkg::CMD_PEEK: begin
                if (list_open) begin
                    words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_LIST,
                                           own_id, 1'b0));
                    words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_LIST,
                                           16'(n_members), n_members == 0));
                    for (int i = 0; i < n_members; i++)
                        words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_LIST,
                                               members[i], i + 1 == n_members));
                end else if (n_joins > 0) begin
                    words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_JOIN,
                                           own_id, 1'b0));
                    words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_JOIN,
                                           joins[0], 1'b1));
                end else if (n_leaves > 0) begin
                    words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_LEAVE,
                                           own_id, 1'b0));
                    words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_LEAVE,
                                           leaves[0], 1'b1));
                end else begin
                    words_due.push_back(mk(smmc_pkg::ST_NONE, smmc_pkg::K_NONE,
                                           '0, 1'b1));
                end
            end
            smmc_pkg::CMD_DROP: begin
                if (list_open) begin
                    list_open = 1'b0;
                    n_members = 0;
                    words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_LIST,
                                           '0, 1'b1));
                end else if (n_joins > 0) begin
                    remove_entry(1, 0);
                    words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_JOIN,
                                           '0, 1'b1));
                end else if (n_leaves > 0) begin
                    remove_entry(2, 0);
                    words_due.push_back(mk(smmc_pkg::ST_OK, smmc_pkg::K_LEAVE,
                                           '0, 1'b1));
                end else begin
                    words_due.push_back(mk(smmc_pkg::ST_NONE, smmc_pkg::K_NONE,
                                           '0, 1'b1));
                end
            end
            default: ; // spare codes: no words
        endcase
    endfunction

    // Compare each strobed word with the oldest expected one.
    always @(posedge i_clk) begin
        t_msg_word got;
        t_msg_word exp_w;
        if (i_rst_n && o_strobe) begin
            got = mk(o_status, o_kind, o_word, o_last);
            if (words_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected word: st=%0d kind=%0d word=%h last=%0d",
                             got.status, got.kind, got.word, got.last);
            end else begin
                exp_w = words_due.pop_front();
                if (got !== exp_w) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"mismatch: exp st=%0d kind=%0d word=%h last=%0d,",
                                  " got st=%0d kind=%0d word=%h last=%0d"},
                                 exp_w.status, exp_w.kind, exp_w.word, exp_w.last,
                                 got.status, got.kind, got.word, got.last);
                end
            end
        end
    end

    // Watchdog: count cycles in which no transfer happens on either side.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one item at the falling edge and hold it until it is taken.
    task automatic send_item(logic [2:0] cmd, logic [15:0] id);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_start = 1'b0;
            repeat ($urandom_range(7)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_start     = 1'b1;
        i_command   = cmd;
        i_member_id = id;
        do @(posedge i_clk); while (o_busy);
        coalesce(cmd, id);
    endtask

    // Hold off until every expected word is in and the block has settled.
    task automatic drain;
        @(negedge i_clk);
        i_start = 1'b0;
        while (words_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
    endtask

    task automatic write_robot_id(logic [15:0] val);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        own_id   = val;
    endtask

    // Empty block: peek, drop and list add report none, spare codes are dropped.
    task automatic test_empty;
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
        send_item(smmc_pkg::CMD_DROP, 16'hFFFF);
        send_item(smmc_pkg::CMD_LIST_ADD, 16'h1234);
        send_item(CMD_SPARE6, 16'hFFFF);
        send_item(CMD_SPARE7, 16'h0000);
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
    endtask

    // Join/leave FIFOs: dedup, cancel, priority of joins over leaves.
    task automatic test_fifo_merge;
        send_item(smmc_pkg::CMD_JOIN, 16'h0000);
        send_item(smmc_pkg::CMD_JOIN, 16'hFFFF);
        send_item(smmc_pkg::CMD_JOIN, 16'h0000);
        send_item(smmc_pkg::CMD_LEAVE, 16'hFFFF);
        send_item(smmc_pkg::CMD_LEAVE, 16'h00AA);
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
        send_item(smmc_pkg::CMD_DROP, 16'h0000);
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
        send_item(smmc_pkg::CMD_DROP, 16'h0000);
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
        send_item(smmc_pkg::CMD_DROP, 16'h0000);
    endtask

    // Full list: empty list message, append, remove with order kept.
    task automatic test_list;
        send_item(smmc_pkg::CMD_JOIN, 16'h0005);
        send_item(smmc_pkg::CMD_LIST_START, 16'h0000);
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
        send_item(smmc_pkg::CMD_LIST_ADD, 16'h0001);
        send_item(smmc_pkg::CMD_LIST_ADD, 16'h0002);
        send_item(smmc_pkg::CMD_JOIN, 16'h0003);
        send_item(smmc_pkg::CMD_JOIN, 16'h0002);
        send_item(smmc_pkg::CMD_LEAVE, 16'h0001);
        send_item(smmc_pkg::CMD_LEAVE, 16'h7777);
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
        send_item(smmc_pkg::CMD_DROP, 16'h0000);
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
    endtask

    // Overflow of the list and of both FIFOs; cancel still happens when full.
    task automatic test_store_full;
        send_item(smmc_pkg::CMD_LIST_START, 16'h0000);
        for (int i = 0; i <= LIST_DEPTH; i++)
            send_item(smmc_pkg::CMD_LIST_ADD, 16'(16'h0100 + i));
        send_item(smmc_pkg::CMD_JOIN, 16'hBEEF);
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
        send_item(smmc_pkg::CMD_DROP, 16'h0000);
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_item(smmc_pkg::CMD_JOIN, 16'(16'h0200 + i));
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_item(smmc_pkg::CMD_LEAVE, 16'(16'h0300 + i));
        send_item(smmc_pkg::CMD_JOIN, 16'h0300);
        send_item(smmc_pkg::CMD_LEAVE, 16'h0200);
        send_item(smmc_pkg::CMD_PEEK, 16'h0000);
        send_item(smmc_pkg::CMD_LIST_START, 16'h0000);
    endtask

    // Mostly short membership traffic over a small id pool so that dedup,
    // cancel and removal actually hit; a few wide ids and spare codes mixed in.
    task automatic test_random_traffic(int count);
        int          pick;
        logic [2:0]  cmd;
        logic [15:0] id;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 26)      cmd = smmc_pkg::CMD_JOIN;
            else if (pick < 46) cmd = smmc_pkg::CMD_LEAVE;
            else if (pick < 51) cmd = smmc_pkg::CMD_LIST_START;
            else if (pick < 66) cmd = smmc_pkg::CMD_LIST_ADD;
            else if (pick < 82) cmd = smmc_pkg::CMD_PEEK;
            else if (pick < 96) cmd = smmc_pkg::CMD_DROP;
            else                cmd = pick[0] ? CMD_SPARE6 : CMD_SPARE7;
            id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(11));
            send_item(cmd, id);
            if (n == count / 2 && count > 20) drain();
        end
    endtask

    initial begin
        own_id    = '0;
        list_open = 1'b0;
        n_members = 0;
        n_joins   = 0;
        n_leaves  = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty();
        write_robot_id(16'hFFFF);
        test_fifo_merge();
        test_list();
        write_robot_id(16'h0000);
        test_store_full();

        // Sender pacing phases, each under a different robot id.
        idle_pct = 0;
        write_robot_id(16'h8000);
        test_random_traffic(34);
        idle_pct = 63;
        write_robot_id(16'h7FFF);
        test_random_traffic(34);
        idle_pct = 21;
        write_robot_id(16'($urandom));
        test_random_traffic(34);
        idle_pct = 0;
        write_robot_id(16'hA5A5);
        test_random_traffic(34);

        drain();
        if (n_errors == 0 && words_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
